FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/escal_pkg.sv
// ----------------------------------------------------------------------------
// escal_pkg
// Types, constants and calendar helper functions for the epoch converter.
// ----------------------------------------------------------------------------
package escal_pkg;

	// Clamp limits and offset, in seconds relative to 1970-01-01.
	localparam logic signed [33:0] T_MIN = -34'sd2208988800;
	localparam logic signed [33:0] T_MAX = 34'sd5869583999;
	localparam logic signed [33:0] T_OFS = 34'sd2208988800;

	localparam logic [7:0] YEAR_LAST = 8'd255;
	localparam logic [7:0] YEAR_2100 = 8'd200;
	localparam logic [3:0] MONTH_DEC = 4'd11;

	// Reciprocal division: q = (x * RCP) >> SH. Each shift is the dividend width
	// plus the bits of the divisor, so the rounding error never reaches a whole
	// step of the quotient. The day step divides the count shifted right by
	// seven (26 bits) by 675, since 86400 is 128 times 675. The other steps see
	// dividends of at most 17 bits.
	localparam int unsigned SH_DAY  = 36;
	localparam int unsigned SH_WDAY = 20;
	localparam int unsigned SH_HOUR = 29;
	localparam int unsigned SH_MIN  = 23;

	localparam logic [26:0] RCP_DAY  = 27'((64'd1 << SH_DAY) / 64'd675 + 64'd1);
	localparam logic [26:0] RCP_WDAY = 27'((64'd1 << SH_WDAY) / 64'd7 + 64'd1);
	localparam logic [26:0] RCP_HOUR = 27'((64'd1 << SH_HOUR) / 64'd3600 + 64'd1);
	localparam logic [26:0] RCP_MIN  = 27'((64'd1 << SH_MIN) / 64'd60 + 64'd1);

	// Division steps run by the shared reciprocal divider.
	typedef enum logic [1:0] {
		OP_DAY  = 2'd0,
		OP_WDAY = 2'd1,
		OP_HOUR = 2'd2,
		OP_MIN  = 2'd3
	} div_op_t;

	typedef struct packed {
		logic    load;
		logic    prep;
		logic    div_step;
		logic    div_end;
		div_op_t op;
		logic    year_phase;
		logic    month_phase;
		logic    write_out;
	} cmd_t;

	typedef struct packed {
		logic year_more;
		logic month_more;
	} sts_t;

	function automatic logic [16:0] div_divisor(input div_op_t op);
		logic [16:0] d;
		case (op)
			OP_DAY:  d = 17'd86400;
			OP_WDAY: d = 17'd7;
			OP_HOUR: d = 17'd3600;
			OP_MIN:  d = 17'd60;
			default: d = 17'd86400;
		endcase
		return d;
	endfunction

	// Year given as an offset from 1900; only 2000 is a century leap year in range.
	function automatic logic is_leap(input logic [7:0] y);
		return (y[1:0] == 2'd0) && (y != 8'd0) && (y != YEAR_2100);
	endfunction

	function automatic logic [8:0] year_len(input logic [7:0] y);
		return is_leap(y) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] n;
		case (m)
			4'd0:    n = 5'd31;
			4'd1:    n = leap ? 5'd29 : 5'd28;
			4'd2:    n = 5'd31;
			4'd3:    n = 5'd30;
			4'd4:    n = 5'd31;
			4'd5:    n = 5'd30;
			4'd6:    n = 5'd31;
			4'd7:    n = 5'd31;
			4'd8:    n = 5'd30;
			4'd9:    n = 5'd31;
			4'd10:   n = 5'd30;
			4'd11:   n = 5'd31;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

FILE: design/escal_ctrl.sv
// ----------------------------------------------------------------------------
// escal_ctrl
// Sequencer for the converter: handshakes, divider steps, year and month walks.
// ----------------------------------------------------------------------------
module escal_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  escal_pkg::sts_t   sts,
	output escal_pkg::cmd_t   cmd
);
	import escal_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CLAMP  = 7'b0000010,
		S_DIV    = 7'b0000100,
		S_DIVEND = 7'b0001000,
		S_YEAR   = 7'b0010000,
		S_MONTH  = 7'b0100000,
		S_WRITE  = 7'b1000000
	} state_t;

	state_t    state_q, state_d;
	div_op_t   op_q, op_d;
	logic      out_valid_q;
	logic      out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cmd     = '0;
		cmd.op  = op_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CLAMP;
				end
			end
			S_CLAMP: begin
				cmd.prep = 1'b1;
				op_d     = OP_DAY;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = S_DIVEND;
			end
			S_DIVEND: begin
				cmd.div_end = 1'b1;
				case (op_q)
					OP_DAY: begin
						op_d    = OP_WDAY;
						state_d = S_DIV;
					end
					OP_WDAY: begin
						op_d    = OP_HOUR;
						state_d = S_DIV;
					end
					OP_HOUR: begin
						op_d    = OP_MIN;
						state_d = S_DIV;
					end
					default: begin
						state_d = S_YEAR;
					end
				endcase
			end
			S_YEAR: begin
				cmd.year_phase = 1'b1;
				if (!sts.year_more) begin
					state_d = S_MONTH;
				end
			end
			S_MONTH: begin
				cmd.month_phase = 1'b1;
				if (!sts.month_more) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				if (out_free) begin
					cmd.write_out = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_DAY;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.write_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/escal_dp.sv
// ----------------------------------------------------------------------------
// escal_dp
// Datapath: offset and clamp, reciprocal divider, year and month walks,
// and the result register.
// ----------------------------------------------------------------------------
module escal_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic signed [16:0] cfg_wdata,
	input  logic signed [32:0] epoch_seconds,
	input  logic               use_local,
	input  escal_pkg::cmd_t    cmd,
	output escal_pkg::sts_t    sts,
	output logic [7:0]         year_since_1900,
	output logic [3:0]         month_index,
	output logic [4:0]         month_day,
	output logic [8:0]         year_day,
	output logic [2:0]         week_day,
	output logic [4:0]         hour_of_day,
	output logic [5:0]         minute_of_hour,
	output logic [5:0]         second_of_minute
);
	import escal_pkg::*;

	logic signed [16:0] zone_q;
	logic signed [33:0] t_adj_q;
	logic signed [33:0] t_clamp;
	logic signed [33:0] s_sum;
	logic [32:0]        dvd_q;
	logic [16:0]        quo_q;
	logic [16:0]        days_q;
	logic [16:0]        secs_q;
	logic [2:0]         wday_q;
	logic [4:0]         hour_q;
	logic [5:0]         min_q;
	logic [5:0]         sec_q;
	logic [7:0]         yr_q;
	logic [3:0]         mon_q;
	logic [8:0]         yday_q;
	logic [16:0]        divisor;
	logic [25:0]        mul_a;
	logic [26:0]        mul_b;
	logic [52:0]        prod;
	logic [16:0]        quo;
	logic [16:0]        qd_low;
	logic [16:0]        rem_w;
	logic [8:0]         ylen;
	logic [4:0]         mlen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= '0;
		end else if (cfg_we) begin
			zone_q <= cfg_wdata;
		end
	end

	// Clamp to 1900-01-01 .. 2155-12-31 and rebase the count to 1900.
	always_comb begin
		if (t_adj_q < T_MIN) begin
			t_clamp = T_MIN;
		end else if (t_adj_q > T_MAX) begin
			t_clamp = T_MAX;
		end else begin
			t_clamp = t_adj_q;
		end
	end
	assign s_sum = t_clamp + T_OFS;

	// Quotient in the step cycle, remainder in the following one. The remainder
	// is below 2^17, so the low 17 bits of dividend minus quotient times divisor
	// give it exactly.
	always_comb begin
		case (cmd.op)
			OP_DAY: begin
				mul_a = dvd_q[32:7];
				mul_b = RCP_DAY;
			end
			OP_WDAY: begin
				mul_a = {9'd0, dvd_q[16:0]};
				mul_b = RCP_WDAY;
			end
			OP_HOUR: begin
				mul_a = {9'd0, dvd_q[16:0]};
				mul_b = RCP_HOUR;
			end
			default: begin
				mul_a = {9'd0, dvd_q[16:0]};
				mul_b = RCP_MIN;
			end
		endcase
	end
	assign prod = {27'd0, mul_a} * {26'd0, mul_b};

	always_comb begin
		case (cmd.op)
			OP_DAY:  quo = 17'(prod >> SH_DAY);
			OP_WDAY: quo = 17'(prod >> SH_WDAY);
			OP_HOUR: quo = 17'(prod >> SH_HOUR);
			default: quo = 17'(prod >> SH_MIN);
		endcase
	end

	assign divisor = div_divisor(cmd.op);
	assign qd_low  = quo_q * divisor;
	assign rem_w   = dvd_q[16:0] - qd_low;

	assign ylen           = year_len(yr_q);
	assign mlen           = month_len(is_leap(yr_q), mon_q);
	assign sts.year_more  = (days_q >= {8'd0, ylen}) && (yr_q != YEAR_LAST);
	assign sts.month_more = (mon_q < MONTH_DEC) && (days_q >= {12'd0, mlen});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_adj_q <= {epoch_seconds[32], epoch_seconds}
				- (use_local ? {{17{zone_q[16]}}, zone_q} : 34'sd0);
		end
		if (cmd.prep) begin
			dvd_q <= s_sum[32:0];
			yr_q  <= '0;
			mon_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q <= quo;
		end
		if (cmd.div_end) begin
			case (cmd.op)
				OP_DAY: begin
					days_q <= quo_q;
					secs_q <= rem_w;
					dvd_q  <= {16'd0, quo_q + 17'd1};
				end
				OP_WDAY: begin
					wday_q <= rem_w[2:0];
					dvd_q  <= {16'd0, secs_q};
				end
				OP_HOUR: begin
					hour_q <= quo_q[4:0];
					dvd_q  <= {16'd0, rem_w};
				end
				default: begin
					min_q <= quo_q[5:0];
					sec_q <= rem_w[5:0];
				end
			endcase
		end
		if (cmd.year_phase) begin
			if (sts.year_more) begin
				days_q <= days_q - {8'd0, ylen};
				yr_q   <= yr_q + 8'd1;
			end else begin
				yday_q <= days_q[8:0];
			end
		end
		if (cmd.month_phase && sts.month_more) begin
			days_q <= days_q - {12'd0, mlen};
			mon_q  <= mon_q + 4'd1;
		end
		if (cmd.write_out) begin
			year_since_1900  <= yr_q;
			month_index      <= mon_q;
			month_day        <= days_q[4:0] + 5'd1;
			year_day         <= yday_q;
			week_day         <= wday_q;
			hour_of_day      <= hour_q;
			minute_of_hour   <= min_q;
			second_of_minute <= sec_q;
		end
	end

endmodule

FILE: design/epoch_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts signed seconds since 1970-01-01 into a broken-down Gregorian date.
// ----------------------------------------------------------------------------
// Usage:
// An input transfer on in_valid/in_ready carries epoch_seconds and use_local.
// When use_local is set, the zone offset (seconds west of UTC, written through
// cfg_we/cfg_wdata and reset to zero) is subtracted before conversion.
// Each input transfer yields exactly one output transfer on out_valid/out_ready.
// The block works on one item at a time. The work on an item runs through
// the offset and clamp, four divisions (days, weekday, hour, minute), each a
// quotient step and a remainder step, a year walk with one step per whole
// year after 1900, a month walk with one step per month index, a closing step
// of each walk and the write of the result register. in_ready rises in the
// cycle that out_valid rises, so a new item is taken only once the last one
// has been written to the output register.
// The result sits in an output register, so a new input transfer is taken
// while the receiver stalls; that item finishes its work and then waits until
// the output register is free. After reset in_ready is high, out_valid is low
// and the zone offset is zero.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic signed [16:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [32:0] epoch_seconds,
	input  logic               use_local,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         year_since_1900,
	output logic [3:0]         month_index,
	output logic [4:0]         month_day,
	output logic [8:0]         year_day,
	output logic [2:0]         week_day,
	output logic [4:0]         hour_of_day,
	output logic [5:0]         minute_of_hour,
	output logic [5:0]         second_of_minute
);
	import escal_pkg::*;

	`include "assert_macros.svh"

	cmd_t       cmd;
	sts_t       sts;
	logic [6:0] phase_bits;
	logic       fields_ok;

	// The controller sequences the work; all arithmetic sits in the datapath.
	escal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	escal_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.epoch_seconds    (epoch_seconds),
		.use_local        (use_local),
		.cmd              (cmd),
		.sts              (sts),
		.year_since_1900  (year_since_1900),
		.month_index      (month_index),
		.month_day        (month_day),
		.year_day         (year_day),
		.week_day         (week_day),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute)
	);

	// Datapath phases and the range checks of a presented result.
	assign phase_bits = {cmd.load, cmd.prep, cmd.div_step, cmd.div_end,
		cmd.year_phase, cmd.month_phase, cmd.write_out};
	assign fields_ok = (month_index <= 4'd11) && (week_day <= 3'd6)
		&& (hour_of_day <= 5'd23) && (minute_of_hour <= 6'd59)
		&& (second_of_minute <= 6'd59) && (month_day != 5'd0);

	// A result must never overwrite one the receiver has not yet taken.
	`ASSERT_IMPLIES(a_no_overwrite, cmd.write_out, (!out_valid || out_ready), "result overwritten")

	// After an input transfer the block is busy with that item.
	`ASSERT_NEXT(a_busy_after_accept, (in_valid && in_ready), !in_ready, "accepted while busy")

	// The controller drives at most one datapath phase in any cycle.
	`ASSERT_IMPLIES(a_one_phase, 1'b1, $onehot0(phase_bits), "phases overlap")

	// Every presented result has its month, weekday, day-of-month and time fields in range.
	`ASSERT_IMPLIES(a_fields_range, out_valid, fields_ok, "result field out of range")

endmodule
